FILE: hdl/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg: shared definitions for the periodic task tick scheduler
// Field widths, mode and kind codes, sequencer states and the record
// returned by the shared countdown unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ptts_pkg;

  // Default number of task slots
  localparam int TASK_SLOTS_DEF = 8;

  // Field widths
  localparam int SLOT_W      = 4;
  localparam int TIME_W      = 16;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // Input item selector (travels on s_tuser)
  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_CREATE = 1'b1;

  // Result kind (travels on m_tuser)
  localparam logic KIND_CREATE = 1'b0;
  localparam logic KIND_DUE    = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  // Result of the shared countdown unit for one slot
  typedef struct packed {
    logic              due;
    logic [TIME_W-1:0] next_count;
  } dec_t;

endpackage

`default_nettype wire

FILE: hdl/ptts_dec_unit.sv
// ----------------------------------------------------------------------------
// ptts_dec_unit: shared countdown unit
// Tests a slot's countdown for zero and forms its next value: period - 1
// on a due slot (wrapping to all ones for a zero period), countdown - 1
// otherwise. One compare and one subtractor serve every slot.
// ----------------------------------------------------------------------------
`default_nettype none

module ptts_dec_unit (
  input  wire logic [ptts_pkg::TIME_W-1:0] count,
  input  wire logic [ptts_pkg::TIME_W-1:0] period,
  output ptts_pkg::dec_t                   res
);

  logic                        is_zero;
  logic [ptts_pkg::TIME_W-1:0] operand;

  // Select reload or decrement, then one shared subtract
  always_comb begin
    is_zero        = (count == '0);
    operand        = is_zero ? period : count;
    res.due        = is_zero;
    res.next_count = operand - ptts_pkg::TIME_W'(1);
  end

endmodule

`default_nettype wire

FILE: hdl/periodic_task_tick_scheduler.sv
// Create item: its acknowledgement is valid in the cycle after it is accepted.
// Tick item: the sequencer walks one slot per cycle through the shared countdown
//   unit unless output back-pressure holds it, then flushes the held due result.
// Each due slot gives one result; output back-pressure stalls the walk.
// s_tready is high only when idle and the output register is free or draining.
// Reset (rst, synchronous) clears all slot valid bits, the sequencer and m_tvalid.
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler: time-triggered cooperative task scheduler
// A table of task slots with period, countdown and valid bit. Create items
// program a slot; tick items report due slots in ascending order.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_tick_scheduler #(
  parameter int TASK_SLOTS = ptts_pkg::TASK_SLOTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Input stream
  input  wire logic                             s_tvalid,
  output      logic                             s_tready,
  // [3:0] slot, [19:4] period, [35:20] first_delay, [36] handler_valid
  input  wire logic [ptts_pkg::IN_TDATA_W-1:0]  s_tdata,
  // [0] mode
  input  wire logic                             s_tuser,
  // Result stream
  output      logic                             m_tvalid,
  input  wire logic                             m_tready,
  // [3:0] task_index, [4] error
  output      logic [ptts_pkg::OUT_TDATA_W-1:0] m_tdata,
  // [0] kind
  output      logic                             m_tuser,
  output      logic                             m_tlast
);

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TASK_SLOTS - 1);
  localparam int SLOT_W = ptts_pkg::SLOT_W;
  localparam int TIME_W = ptts_pkg::TIME_W;

  // Input field unpack
  logic [SLOT_W-1:0] in_slot;
  logic [TIME_W-1:0] in_period;
  logic [TIME_W-1:0] in_first;
  logic              in_handler;
  logic              create_ok;

  assign in_slot    = s_tdata[3:0];
  assign in_period  = s_tdata[19:4];
  assign in_first   = s_tdata[35:20];
  assign in_handler = s_tdata[36];
  assign create_ok  = in_handler && ({1'b0, in_slot} < (SLOT_W + 1)'(TASK_SLOTS));

  // Slot tables
  logic [TIME_W-1:0]     period_tab [TASK_SLOTS];
  logic [TIME_W-1:0]     count_tab  [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] slot_valid;

  // Sequencer and pending result
  ptts_pkg::state_t state, state_next;
  logic [IDX_W-1:0] idx;
  logic             pend_valid;
  logic [IDX_W-1:0] pend_idx;

  // Output register payload
  logic              out_kind;
  logic [SLOT_W-1:0] out_task;
  logic              out_err;
  logic              out_last;

  // Control
  logic              out_free;
  logic              in_take;
  logic              tab_wr;
  logic              walk_step;
  logic              cd_we;
  logic              pend_set;
  logic              pend_clr;
  logic              out_load;
  logic              ld_kind;
  logic [SLOT_W-1:0] ld_task;
  logic              ld_err;
  logic              ld_last;
  logic              slot_hit;

  ptts_pkg::dec_t dec;

  // Shared countdown unit on the slot under visit
  ptts_dec_unit u_dec (
    .count  (count_tab[idx]),
    .period (period_tab[idx]),
    .res    (dec)
  );

  assign out_free = !m_tvalid || m_tready;
  assign in_take  = s_tvalid && s_tready;
  assign slot_hit = slot_valid[idx];

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ptts_pkg::ST_IDLE: begin
        if (in_take && (s_tuser == ptts_pkg::MODE_TICK)) state_next = ptts_pkg::ST_WALK;
      end
      ptts_pkg::ST_WALK: begin
        if (walk_step && (idx == IDX_LAST)) state_next = ptts_pkg::ST_FLUSH;
      end
      ptts_pkg::ST_FLUSH: begin
        if (!pend_valid || out_free) state_next = ptts_pkg::ST_IDLE;
      end
      default: state_next = ptts_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    tab_wr    = 1'b0;
    walk_step = 1'b0;
    cd_we     = 1'b0;
    pend_set  = 1'b0;
    pend_clr  = 1'b0;
    out_load  = 1'b0;
    ld_kind   = ptts_pkg::KIND_DUE;
    ld_task   = SLOT_W'(pend_idx);
    ld_err    = 1'b0;
    ld_last   = 1'b0;
    case (state)
      ptts_pkg::ST_IDLE: begin
        s_tready = out_free;
        if (in_take && (s_tuser == ptts_pkg::MODE_CREATE)) begin
          tab_wr   = create_ok;
          out_load = 1'b1;
          ld_kind  = ptts_pkg::KIND_CREATE;
          ld_task  = in_slot;
          ld_err   = !create_ok;
          ld_last  = 1'b1;
        end
      end
      ptts_pkg::ST_WALK: begin
        // A second due slot pushes the held one out; stall if the output is busy
        if (slot_hit && dec.due && pend_valid) begin
          walk_step = out_free;
          out_load  = out_free;
        end else begin
          walk_step = 1'b1;
        end
        cd_we    = slot_hit && walk_step;
        pend_set = slot_hit && dec.due && walk_step;
      end
      ptts_pkg::ST_FLUSH: begin
        // Held result is the final one of this tick
        if (pend_valid && out_free) begin
          out_load = 1'b1;
          ld_last  = 1'b1;
          pend_clr = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ptts_pkg::ST_IDLE;
      idx        <= '0;
      pend_valid <= 1'b0;
      slot_valid <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (walk_step) idx <= (idx == IDX_LAST) ? '0 : idx + 1'b1;
      if (pend_set) begin
        pend_valid <= 1'b1;
      end else if (pend_clr) begin
        pend_valid <= 1'b0;
      end
      if (tab_wr) slot_valid[in_slot[IDX_W-1:0]] <= 1'b1;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Table and payload registers
  always_ff @(posedge clk) begin
    if (tab_wr) begin
      period_tab[in_slot[IDX_W-1:0]] <= in_period;
      count_tab[in_slot[IDX_W-1:0]]  <= in_first;
    end else if (cd_we) begin
      count_tab[idx] <= dec.next_count;
    end
    if (pend_set) pend_idx <= idx;
    if (out_load) begin
      out_kind <= ld_kind;
      out_task <= ld_task;
      out_err  <= ld_err;
      out_last <= ld_last;
    end
  end

  assign m_tdata = {3'b000, out_err, out_task};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule

`default_nettype wire

FILE: hdl/ptts_checker.sv
// ----------------------------------------------------------------------------
// ptts_checker: port-level checks for the task tick scheduler
// Watches both stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ptts_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tvalid,
  input wire logic                             s_tready,
  input wire logic [ptts_pkg::IN_TDATA_W-1:0]  s_tdata,
  input wire logic                             s_tuser,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [ptts_pkg::OUT_TDATA_W-1:0] m_tdata,
  input wire logic                             m_tuser,
  input wire logic                             m_tlast
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // A create is acknowledged in the next cycle with its slot echoed
  a_create_ack: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == ptts_pkg::MODE_CREATE)
      |=> m_tvalid && (m_tuser == ptts_pkg::KIND_CREATE) && m_tlast
        && (m_tdata[3:0] == $past(s_tdata[3:0])))
    else $error("create acknowledgement missing or wrong");

  // Due results never carry an error
  a_due_no_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ptts_pkg::KIND_DUE) |-> !m_tdata[4])
    else $error("due result flagged as error");

  // Input is taken only when the output register can take a result
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid || m_tready)
    else $error("input ready while output blocked");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for periodic_task_tick_scheduler
// Mixes create and tick items, some directed and some random, with random
// gaps on both streams. A task table model predicts every acknowledgement
// and due report, and each result transfer is checked field by field.
// ----------------------------------------------------------------------------

module testbench;

  localparam int TASK_SLOTS  = ptts_pkg::TASK_SLOTS_DEF;
  localparam int SLOT_W      = ptts_pkg::SLOT_W;
  localparam int TIME_W      = ptts_pkg::TIME_W;
  localparam int IN_TDATA_W  = ptts_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = ptts_pkg::OUT_TDATA_W;
  // One tick walks every slot, then flushes its held result
  localparam int SETTLE      = 2 * (TASK_SLOTS + 2) + 4;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 130;

  // One input item, split into its fields
  typedef struct {
    logic              mode;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] first_delay;
    logic              handler;
  } sched_item_t;

  // One expected result
  typedef struct {
    logic              kind;
    logic [SLOT_W-1:0] task_index;
    logic              error;
    logic              last;
  } sched_result_t;

  // --------------------------------------------------------------------------
  // Task table model and result checker
  // --------------------------------------------------------------------------
  class task_table_checker;
    logic [TIME_W-1:0] period_tbl [TASK_SLOTS];
    logic [TIME_W-1:0] countdown_tbl [TASK_SLOTS];
    bit                slot_live [TASK_SLOTS];
    sched_result_t     pending_runs [$];
    int errors, n_items, n_create, n_reject, n_tick, n_quiet, n_due, max_burst;

    function new();
      for (int i = 0; i < TASK_SLOTS; i++) begin
        period_tbl[i]    = '0;
        countdown_tbl[i] = '0;
        slot_live[i]     = 1'b0;
      end
    endfunction

    function int pending();
      return pending_runs.size();
    endfunction

    // Update the table for an accepted item and queue what it must produce
    function void note_item(sched_item_t it);
      sched_result_t r;
      int hits;
      hits = 0;
      n_items++;
      if (it.mode == ptts_pkg::MODE_CREATE) begin
        n_create++;
        r.kind       = ptts_pkg::KIND_CREATE;
        r.task_index = it.slot;
        r.error      = 1'b1;
        r.last       = 1'b1;
        if (it.handler && it.slot < TASK_SLOTS) begin
          period_tbl[it.slot]    = it.period;
          countdown_tbl[it.slot] = it.first_delay;
          slot_live[it.slot]     = 1'b1;
          r.error                = 1'b0;
        end else begin
          n_reject++;
        end
        pending_runs.push_back(r);
      end else begin
        n_tick++;
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (slot_live[i]) begin
            if (countdown_tbl[i] == '0) begin
              r.kind       = ptts_pkg::KIND_DUE;
              r.task_index = SLOT_W'(i);
              r.error      = 1'b0;
              r.last       = 1'b0;
              pending_runs.push_back(r);
              hits++;
              // period zero wraps to the full count
              countdown_tbl[i] = period_tbl[i] - 1'b1;
            end else begin
              countdown_tbl[i] = countdown_tbl[i] - 1'b1;
            end
          end
        end
        if (hits > 0) begin
          r = pending_runs[$];
          pending_runs.pop_back();
          r.last = 1'b1;
          pending_runs.push_back(r);
        end else begin
          n_quiet++;
        end
        n_due += hits;
        if (hits > max_burst) max_burst = hits;
      end
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      end
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_result(logic kind, logic [SLOT_W-1:0] idx, logic err, logic last);
      sched_result_t e;
      if (pending_runs.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %s",
                 $time, $sformatf("kind=%0d task=%0d err=%0d last=%0d",
                                  kind, idx, err, last));
        return;
      end
      e = pending_runs.pop_front();
      compare_field("kind", 8'(e.kind), 8'(kind));
      compare_field("task_index", 8'(e.task_index), 8'(idx));
      compare_field("error", 8'(e.error), 8'(err));
      compare_field("last", 8'(e.last), 8'(last));
    endfunction

    // Flag anything never delivered and summarize the run
    function void close();
      if (pending_runs.size() != 0) begin
        errors++;
        $display("%0t: %0d results still expected, actual none", $time, pending_runs.size());
      end
      $display("Run covered %0d items: %0d creates (%0d rejected), %0d ticks (%0d quiet).",
               n_items, n_create, n_reject, n_tick, n_quiet);
      $display("Checked %0d due reports, up to %0d from one tick.", n_due, max_burst);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block
  // --------------------------------------------------------------------------
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;

  int src_idle = 12;
  int dst_idle = 61;
  int stall_cycles = 0;

  task_table_checker sb = new();

  periodic_task_tick_scheduler #(
    .TASK_SLOTS(TASK_SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= dst_idle);
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tuser, m_tdata[3:0], m_tdata[4], m_tlast);
    end
  end

  // Watchdog: no transfer on either stream for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic sched_item_t make_item(logic mode, logic [SLOT_W-1:0] slot,
                                            logic [TIME_W-1:0] period,
                                            logic [TIME_W-1:0] first_delay,
                                            logic handler);
    sched_item_t it;
    it.mode        = mode;
    it.slot        = slot;
    it.period      = period;
    it.first_delay = first_delay;
    it.handler     = handler;
    return it;
  endfunction

  // Mostly small periods and delays so that tasks fall due often
  function automatic sched_item_t random_item();
    sched_item_t it;
    int pick;
    it.mode = ($urandom_range(99) < 30) ? ptts_pkg::MODE_CREATE : ptts_pkg::MODE_TICK;
    it.slot = ($urandom_range(99) < 85) ? SLOT_W'($urandom_range(TASK_SLOTS - 1))
                                        : SLOT_W'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 80)      it.period = TIME_W'($urandom_range(1, 6));
    else if (pick < 88) it.period = '0;
    else                it.period = TIME_W'($urandom());
    it.first_delay = ($urandom_range(99) < 80) ? TIME_W'($urandom_range(0, 6))
                                               : TIME_W'($urandom());
    it.handler = ($urandom_range(99) < 92);
    return it;
  endfunction

  // Drive one item after a random gap and hold it until the transfer
  task automatic send_item(sched_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.mode;
    s_tdata  <= IN_TDATA_W'({it.handler, it.first_delay, it.period, it.slot});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(it);
  endtask

  // Hold off the sender until every expected result has arrived
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_directed();
    // empty table: nothing due
    send_item(make_item(ptts_pkg::MODE_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0));
    // rejected creates: out of range, first invalid slot, no handler
    send_item(make_item(ptts_pkg::MODE_CREATE, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1));
    send_item(make_item(ptts_pkg::MODE_CREATE, SLOT_W'(TASK_SLOTS), 16'h0001, 16'h0000,
                        1'b1));
    send_item(make_item(ptts_pkg::MODE_CREATE, 4'd0, 16'h0001, 16'h0000, 1'b0));
    send_item(make_item(ptts_pkg::MODE_TICK, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1));
    // zero period, extreme values, small periods
    send_item(make_item(ptts_pkg::MODE_CREATE, 4'd0, 16'h0000, 16'h0000, 1'b1));
    send_item(make_item(ptts_pkg::MODE_CREATE, SLOT_W'(TASK_SLOTS - 1), 16'hFFFF, 16'hFFFF,
                        1'b1));
    send_item(make_item(ptts_pkg::MODE_CREATE, 4'd1, 16'h0001, 16'h0000, 1'b1));
    send_item(make_item(ptts_pkg::MODE_CREATE, 4'd2, 16'h0003, 16'h0001, 1'b1));
    repeat (3) send_item(make_item(ptts_pkg::MODE_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0));
    // replace a live task, then a tick with nothing due
    send_item(make_item(ptts_pkg::MODE_CREATE, 4'd1, 16'h0004, 16'h0002, 1'b1));
    send_item(make_item(ptts_pkg::MODE_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0));
    // every slot due on the same tick
    for (int i = 0; i < TASK_SLOTS; i++)
      send_item(make_item(ptts_pkg::MODE_CREATE, SLOT_W'(i), 16'h0001, 16'h0000, 1'b1));
    repeat (2) send_item(make_item(ptts_pkg::MODE_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(ptts_pkg::MODE_CREATE, 4'd5, 16'h0002, 16'h0002, 1'b0));
  endtask

  task automatic run_phase(int tx_idle, int rx_idle);
    src_idle = tx_idle;
    dst_idle = rx_idle;
    repeat (PHASE_ITEMS) send_item(random_item());
    drain();
  endtask

  // Main sequence
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    drain();
    run_phase(12, 61);
    run_phase(61, 12);
    run_phase(0, 0);

    sb.close();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
